@@ hw/rtl/fmbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbq_pkg: shared types for the front/middle/back queue
// Operation and status codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package fmbq_pkg;

  // Operation codes carried by the func field.
  typedef enum logic [2:0] {
    FN_PUSH_FRONT  = 3'd0,
    FN_PUSH_MIDDLE = 3'd1,
    FN_PUSH_BACK   = 3'd2,
    FN_POP_FRONT   = 3'd3,
    FN_POP_MIDDLE  = 3'd4,
    FN_POP_BACK    = 3'd5
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch the operation and issue the memory reads
    logic commit;   // write the halves, move the pointers, load the result
  } cmd_t;

endpackage

@@ hw/rtl/fmbq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbq_ctrl: queue controller
// Two-state sequencer (read, then write back) and the output valid flag.
// ----------------------------------------------------------------------------
module fmbq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output fmbq_pkg::cmd_t  cmd
);
  import fmbq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  // The result register can take a new transaction when empty or being drained.
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.commit = (state == S_EXEC) && slot_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A committed operation always shows up as a pending result.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");

  // An accepted transaction blocks further input until it is committed.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  // A stalled result keeps the operation parked in the write-back state.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && out_valid && !out_ready |=> (state == S_EXEC))
    else $error("operation left write-back while the result was stalled");

endmodule

@@ hw/rtl/fmbq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbq_datapath: queue storage and pointer arithmetic
// Two ring-buffer halves with head and count registers, plus the result
// register. Reads are issued on accept, writes and updates on commit.
// ----------------------------------------------------------------------------
module fmbq_datapath #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  fmbq_pkg::cmd_t     cmd,
  input  logic [2:0]         func,
  input  logic signed [31:0] value_in,
  output logic signed [31:0] value_out,
  output logic [1:0]         status
);
  import fmbq_pkg::*;

  localparam int HD    = (CAPACITY + 1) / 2;
  localparam int PTR_W = (HD > 1) ? $clog2(HD) : 1;
  localparam int CNT_W = $clog2(HD + 1);
  localparam int SUM_W = CNT_W + 1;

  // Ring position: (p + n - dec) modulo the half depth.
  function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n,
                                                input logic dec);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n) - SUM_W'(dec);
    if (s >= SUM_W'(HD)) begin
      s = s - SUM_W'(HD);
    end
    return s[PTR_W-1:0];
  endfunction

  // Storage of the two halves.
  logic [DATA_WIDTH-1:0] fmem [HD];
  logic [DATA_WIDTH-1:0] bmem [HD];

  // Pointer state.
  logic [PTR_W-1:0] fh, bh, fh_next, bh_next;
  logic [CNT_W-1:0] fc, bc, fc_next, bc_next;

  // Operation registers and read data.
  func_t                 op;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] frd, brd;
  logic [31:0]           in_bits;

  // Derived positions.
  logic [PTR_W-1:0] fh_inc, fh_dec, bh_inc, bh_dec;
  logic [PTR_W-1:0] f_tail, f_last, b_tail, b_last;
  logic [PTR_W-1:0] f_raddr, b_raddr;
  logic             balanced, full, empty;
  logic [CNT_W:0]   total;

  // Write ports and result.
  logic                  f_we, b_we;
  logic [PTR_W-1:0]      f_waddr, b_waddr;
  logic [DATA_WIDTH-1:0] f_wdata, b_wdata;
  logic [DATA_WIDTH-1:0] res;
  status_t               st;

  assign fh_inc = ring_pos(fh, CNT_W'(1), 1'b0);
  assign fh_dec = ring_pos(fh, CNT_W'(HD - 1), 1'b0);
  assign bh_inc = ring_pos(bh, CNT_W'(1), 1'b0);
  assign bh_dec = ring_pos(bh, CNT_W'(HD - 1), 1'b0);
  assign f_tail = ring_pos(fh, fc, 1'b0);
  assign f_last = ring_pos(fh, fc, 1'b1);
  assign b_tail = ring_pos(bh, bc, 1'b0);
  assign b_last = ring_pos(bh, bc, 1'b1);

  assign total    = (CNT_W + 1)'(fc) + (CNT_W + 1)'(bc);
  assign balanced = (fc == bc);
  assign full     = (total >= (CNT_W + 1)'(CAPACITY));
  assign empty    = (total == '0);

  // Read addresses depend on the incoming operation.
  assign f_raddr = (func == FN_POP_FRONT) ? fh : f_last;
  assign b_raddr = (func == FN_POP_BACK) ? b_last : bh;
  assign in_bits = value_in;

  // Capture the transaction and read one word of each half.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op    <= func_t'(func);
      val_q <= DATA_WIDTH'(in_bits);
      frd   <= fmem[f_raddr];
      brd   <= bmem[b_raddr];
    end
  end

  // Write-back decisions for the captured operation.
  always_comb begin
    f_we    = 1'b0;
    b_we    = 1'b0;
    f_waddr = f_tail;
    b_waddr = b_tail;
    f_wdata = val_q;
    b_wdata = val_q;
    fh_next = fh;
    bh_next = bh;
    fc_next = fc;
    bc_next = bc;
    res     = '0;
    st      = ST_OK;
    case (op)
      FN_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          if (!balanced) begin
            // Last front word moves to the front of the back half.
            b_we    = 1'b1;
            b_waddr = bh_dec;
            b_wdata = frd;
            bh_next = bh_dec;
            bc_next = bc + CNT_W'(1);
          end else begin
            fc_next = fc + CNT_W'(1);
          end
          f_we    = 1'b1;
          f_waddr = fh_dec;
          fh_next = fh_dec;
        end
      end
      FN_PUSH_MIDDLE: begin
        if (full) begin
          st = ST_FULL;
        end else if (!balanced) begin
          // Old middle goes to the back half; the new word takes its slot.
          b_we    = 1'b1;
          b_waddr = bh_dec;
          b_wdata = frd;
          bh_next = bh_dec;
          bc_next = bc + CNT_W'(1);
          f_we    = 1'b1;
          f_waddr = f_last;
        end else begin
          f_we    = 1'b1;
          f_waddr = f_tail;
          fc_next = fc + CNT_W'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else if (balanced && (bc == '0)) begin
          f_we    = 1'b1;
          f_waddr = f_tail;
          fc_next = fc + CNT_W'(1);
        end else if (balanced) begin
          // First back word moves to the end of the front half.
          f_we    = 1'b1;
          f_waddr = f_tail;
          f_wdata = brd;
          fc_next = fc + CNT_W'(1);
          bh_next = bh_inc;
          b_we    = 1'b1;
          b_waddr = b_tail;
        end else begin
          b_we    = 1'b1;
          b_waddr = b_tail;
          bc_next = bc + CNT_W'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          res     = frd;
          fh_next = fh_inc;
          if (balanced) begin
            f_we    = 1'b1;
            f_waddr = f_tail;
            f_wdata = brd;
            bh_next = bh_inc;
            bc_next = bc - CNT_W'(1);
          end else begin
            fc_next = fc - CNT_W'(1);
          end
        end
      end
      FN_POP_MIDDLE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          res = frd;
          if (balanced) begin
            f_we    = 1'b1;
            f_waddr = f_last;
            f_wdata = brd;
            bh_next = bh_inc;
            bc_next = bc - CNT_W'(1);
          end else begin
            fc_next = fc - CNT_W'(1);
          end
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (bc == '0) begin
          res     = frd;
          fc_next = fc - CNT_W'(1);
        end else if (balanced) begin
          res     = brd;
          bc_next = bc - CNT_W'(1);
        end else begin
          // Back half shrinks at its end and gains the old middle at its front.
          res     = brd;
          b_we    = 1'b1;
          b_waddr = bh_dec;
          b_wdata = frd;
          bh_next = bh_dec;
          fc_next = fc - CNT_W'(1);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (cmd.commit && f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (cmd.commit && b_we) begin
      bmem[b_waddr] <= b_wdata;
    end
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fh <= '0;
      bh <= '0;
      fc <= '0;
      bc <= '0;
    end else if (cmd.commit) begin
      fh <= fh_next;
      bh <= bh_next;
      fc <= fc_next;
      bc <= bc_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      value_out <= 32'(res);
      status    <= st;
    end
  end

  // The front half holds as many words as the back half, or one more.
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (fc == bc) || (fc == bc + CNT_W'(1)))
    else $error("halves out of balance");

endmodule

@@ hw/rtl/front_middle_back_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_middle_back_queue: queue with push and pop at front, middle and back
// Holds up to CAPACITY words as two ring-buffer halves kept in balance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries func and value_in. Codes are
//   push front, push middle, push back, pop front, pop middle, pop back;
//   other codes do nothing and report ok.
//   Output channel (out_valid/out_ready) carries value_out and status for
//   every transaction: ok, pop on empty queue, or push on full queue dropped.
//   Pushes and failed pops return zero in value_out.
// Timing:
//   An accepted transaction first reads the end words of both halves, then
//   waits in write-back until the result register is free; there it writes
//   them back, moves the pointers and loads the result. A new transaction
//   is accepted only after the previous one has committed.
// Reset:
//   Reset empties the queue at once by clearing heads and counts; there is
//   no memory clearing pass.
// Stalls:
//   A result held by out_ready low keeps the next transaction in write-back;
//   input is taken again once the result register is free.
// ----------------------------------------------------------------------------
module front_middle_back_queue #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] value_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value_out,
  output logic [1:0]         status
);
  import fmbq_pkg::*;

  cmd_t cmd;

  // Sequencer and handshake control.
  fmbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Storage, pointers and result register.
  fmbq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (func),
    .value_in  (value_in),
    .value_out (value_out),
    .status    (status)
  );

endmodule
